@@ hw/rtl/chm_pkg.sv @@
// ---------------------------------------------------------------------------
// chm_pkg
// shared constants, codes and hash stage functions of the chained hash map
// ---------------------------------------------------------------------------
package chm_pkg;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 11;

  typedef logic [KEY_W-1:0] word_t;

  // request opcodes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_HIT      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS     = 2'd1;
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // shift amounts of the integer mix
  localparam int SH_32 = 32'h20;
  localparam int SH_22 = 32'h16;
  localparam int SH_13 = 32'hd;
  localparam int SH_8  = 8;
  localparam int SH_15 = 32'hf;
  localparam int SH_27 = 32'h1b;
  localparam int SH_31 = 32'h1f;

  function automatic word_t sar(input word_t x, input int n);
    return word_t'($signed(x) >>> n);
  endfunction

  // first third: fold, xor-shift, add
  function automatic word_t mix_a(input word_t k);
    word_t h;
    h = ~(k << SH_32) + k;
    h = h ^ sar(h, SH_22);
    h = h + ~(h << SH_13);
    return h;
  endfunction

  // second third: xor-shift, times nine, xor-shift
  function automatic word_t mix_b(input word_t x);
    word_t h;
    h = x ^ sar(x, SH_8);
    h = (h << 3) + h;
    h = h ^ sar(h, SH_15);
    return h;
  endfunction

  // last third: add, xor-shift
  function automatic word_t mix_c(input word_t x);
    word_t h;
    h = x + ~(x << SH_27);
    h = h ^ sar(h, SH_31);
    return h;
  endfunction

endpackage

@@ hw/rtl/chained_hash_map_engine.sv @@
// Each item passes the 3 hash stages, the bucket read, one node read per chain step
// and the output load; the length of the chain walk sets how long an item takes.
// Removes also pass S_FREE, inserts of a new key S_INS, inserts from the free list S_ALLOC and S_INS.
// One item at a time; the next item is taken only once the result of the last is loaded.
// After reset a clearing pass empties the bucket-head memory.
// ---------------------------------------------------------------------------
// chained_hash_map_engine
// key to value map with separate chaining over node memories
// ---------------------------------------------------------------------------
module chained_hash_map_engine
  import chm_pkg::*;
#(
  parameter int BUCKET_BITS = 8,
  parameter int NODES       = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // opcode[1:0], key[65:2], value_in[129:66], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata    // status[1:0], value_out[65:2], entry_count[76:66], pad
);

  localparam int IW = $clog2(NODES);
  localparam int LW = IW + 1;           // link: {valid, index}
  localparam int NB = 1 << BUCKET_BITS;
  localparam logic [IW:0] NODES_C = (IW+1)'(NODES);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_ALLOC = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_FREE  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]             state;
  logic [BUCKET_BITS-1:0] clr_addr;
  logic [OP_W-1:0]        op_q;
  word_t                  key_q;
  word_t                  val_q;
  logic [BUCKET_BITS-1:0] bucket_q;
  logic [LW-1:0]          head_q;
  logic [IW-1:0]          cur;
  logic [IW-1:0]          prev;
  logic                   has_prev;
  logic [IW-1:0]          new_idx;
  logic [IW-1:0]          free_head;
  logic                   free_valid;
  logic [IW:0]            fresh_next;
  logic [IW:0]            live;
  logic [STAT_W-1:0]      status_q;
  word_t                  vout_q;

  logic                   in_acc;
  logic                   hash_done;
  logic [BUCKET_BITS-1:0] hash_bucket;

  logic                   b_we;
  logic [BUCKET_BITS-1:0] b_waddr;
  logic [LW-1:0]          b_wdata;
  logic [BUCKET_BITS-1:0] b_raddr;
  logic [LW-1:0]          b_rdata;

  logic                   k_we;
  logic                   v_we;
  logic [IW-1:0]          v_waddr;
  word_t                  v_wdata;
  logic                   l_we;
  logic [IW-1:0]          l_waddr;
  logic [LW-1:0]          l_wdata;
  logic [IW-1:0]          n_raddr;
  word_t                  k_rdata;
  word_t                  v_rdata;
  logic [LW-1:0]          l_rdata;

  logic key_match;
  logic op_ok;
  logic not_found;

  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign key_match = (k_rdata == key_q);
  assign op_ok     = (op_q == OP_LOOKUP) || (op_q == OP_INSERT) || (op_q == OP_REMOVE);
  assign not_found = ((state == S_HEAD) && op_ok && !b_rdata[IW]) ||
                     ((state == S_WALK) && !key_match && !l_rdata[IW]);

  // key hash
  chm_hash #(.BUCKET_BITS(BUCKET_BITS)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (in_acc),
    .key    (s_tdata[65:2]),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  // memories
  chm_ram #(.WIDTH(LW), .DEPTH(NB)) u_heads (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata)
  );
  chm_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_keys (
    .clk(clk), .we(k_we), .waddr(new_idx), .wdata(key_q), .raddr(n_raddr), .rdata(k_rdata)
  );
  chm_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_vals (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(n_raddr), .rdata(v_rdata)
  );
  chm_ram #(.WIDTH(LW), .DEPTH(NODES)) u_links (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(n_raddr), .rdata(l_rdata)
  );

  // memory port control
  always_comb begin
    b_we    = 1'b0;
    b_waddr = bucket_q;
    b_wdata = '0;
    b_raddr = hash_bucket;
    k_we    = 1'b0;
    v_we    = 1'b0;
    v_waddr = new_idx;
    v_wdata = val_q;
    l_we    = 1'b0;
    l_waddr = new_idx;
    l_wdata = head_q;
    n_raddr = cur;
    unique case (state)
      S_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr_addr;
      end
      S_HEAD: begin
        n_raddr = b_rdata[IW-1:0];
      end
      S_WALK: begin
        if (key_match) begin
          if (op_q == OP_INSERT) begin
            v_we    = 1'b1;
            v_waddr = cur;
          end else if (op_q == OP_REMOVE) begin
            if (has_prev) begin
              l_we    = 1'b1;
              l_waddr = prev;
              l_wdata = l_rdata;
            end else begin
              b_we    = 1'b1;
              b_wdata = l_rdata;
            end
          end
        end else begin
          n_raddr = l_rdata[IW-1:0];
        end
      end
      S_INS: begin
        k_we    = 1'b1;
        v_we    = 1'b1;
        l_we    = 1'b1;
        b_we    = 1'b1;
        b_wdata = {1'b1, new_idx};
      end
      S_FREE: begin
        l_we    = 1'b1;
        l_waddr = cur;
        l_wdata = {free_valid, free_head};
      end
      default: begin
      end
    endcase
    // an insert that misses reads the free-list link
    if (not_found && (op_q == OP_INSERT)) begin
      n_raddr = free_head;
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      free_valid <= 1'b0;
      fresh_next <= '0;
      live       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BUCKET_BITS'(NB - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_q   <= s_tdata[1:0];
            key_q  <= s_tdata[65:2];
            val_q  <= s_tdata[129:66];
            vout_q <= '0;
            state  <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bucket_q <= hash_bucket;
            state    <= S_HEAD;
          end
        end
        S_HEAD: begin
          head_q   <= b_rdata;
          cur      <= b_rdata[IW-1:0];
          has_prev <= 1'b0;
          if (!op_ok) begin
            status_q <= ST_MISS;
            state    <= S_DONE;
          end else if (b_rdata[IW]) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (key_match) begin
            status_q <= ST_HIT;
            if (op_q == OP_LOOKUP) begin
              vout_q <= v_rdata;
            end
            state <= (op_q == OP_REMOVE) ? S_FREE : S_DONE;
          end else if (l_rdata[IW]) begin
            prev     <= cur;
            has_prev <= 1'b1;
            cur      <= l_rdata[IW-1:0];
          end
        end
        S_ALLOC: begin
          new_idx    <= free_head;
          free_head  <= l_rdata[IW-1:0];
          free_valid <= l_rdata[IW];
          state      <= S_INS;
        end
        S_INS: begin
          live     <= live + 1'b1;
          status_q <= ST_INSERTED;
          state    <= S_DONE;
        end
        S_FREE: begin
          free_head  <= cur;
          free_valid <= 1'b1;
          if (live != '0) begin
            live <= live - 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // chain ended without a match
      if (not_found) begin
        if (op_q != OP_INSERT) begin
          status_q <= ST_MISS;
          state    <= S_DONE;
        end else if (free_valid) begin
          state <= S_ALLOC;
        end else if (fresh_next < NODES_C) begin
          new_idx    <= fresh_next[IW-1:0];
          fresh_next <= fresh_next + 1'b1;
          state      <= S_INS;
        end else begin
          status_q <= ST_FULL;
          state    <= S_DONE;
        end
      end
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'b000, COUNT_W'(live), vout_q, status_q};
    end
  end

endmodule

@@ hw/rtl/chm_ram.sv @@
// ---------------------------------------------------------------------------
// chm_ram
// simple dual-port ram, one write port, one read port with registered data
// ---------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/chm_hash.sv @@
// ---------------------------------------------------------------------------
// chm_hash
// three-stage pipelined 64-bit integer mix giving the bucket number
// ---------------------------------------------------------------------------
module chm_hash
  import chm_pkg::*;
#(
  parameter int BUCKET_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  word_t                  key,
  output logic                   done,
  output logic [BUCKET_BITS-1:0] bucket
);

  word_t      s1;
  word_t      s2;
  word_t      s3;
  logic [2:0] vld;

  // stage valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], start};
    end
  end

  // last mix stage ahead of the bucket register
  assign s3 = mix_c(s2);

  // mix stages
  always_ff @(posedge clk) begin
    s1     <= mix_a(key);
    s2     <= mix_b(s1);
    bucket <= s3[BUCKET_BITS-1:0];
  end

  assign done = vld[2];

endmodule

@@ hw/rtl/chm_checker.sv @@
// ---------------------------------------------------------------------------
// chm_checker
// port-level checks of the chained hash map engine
// ---------------------------------------------------------------------------
module chm_checker
  import chm_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [135:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [79:0]  m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing comes out and no input is taken straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("block active after reset");

  // one item in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken during work");

  // a value only comes back with a hit
  a_value_on_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[65:2] == '0) || (m_tdata[1:0] == ST_HIT))
    else $error("value returned without hit");

endmodule

bind chained_hash_map_engine chm_checker u_chm_checker (.*);
